### rtl/core/nvcs_pkg.sv
// Shared constants, types and command/status bundles for the checksum-guarded byte store.
package nvcs_pkg;

   // Store geometry.
   localparam int USER_BYTES  = 48;
   localparam int CLOCK_BYTES = 14;
   localparam int STORE_BYTES = CLOCK_BYTES + USER_BYTES + 2;
   localparam int SUM_ADDR    = CLOCK_BYTES + USER_BYTES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int UIDX_W      = $clog2(USER_BYTES);

   // Initialization pattern placed in the user area outside tt mode.
   localparam int PATTERN_AT    = 8;
   localparam int PATTERN_LEN   = 6;
   localparam int PAT_W         = $clog2(PATTERN_LEN);
   localparam bit PATTERN_FITS  = (PATTERN_AT + PATTERN_LEN <= USER_BYTES);

   // Fixed field widths.
   localparam int OP_W   = 3;
   localparam int IDX_W  = 6;
   localparam int BYTE_W = 8;
   localparam int ST_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_RANGE_RD = 3'd0,
      OP_RANGE_WR = 3'd1,
      OP_RESET    = 3'd2,
      OP_CLK_RD   = 3'd3,
      OP_CLK_WR   = 3'd4
   } op_type;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_NODEV = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD   = 2'd2;
   localparam logic [ST_W-1:0] ST_SUM   = 2'd3;

   localparam logic CSR_DEVICE_PRESENT = 1'b0;
   localparam logic CSR_TT_MODE        = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INIT_WALK,
      S_SUM_WALK,
      S_SUM_HI,
      S_SUM_LO,
      S_SUM_CHECK,
      S_WR_HI,
      S_WR_LO,
      S_CLK_OUT,
      S_STREAM_RD,
      S_STREAM_OUT,
      S_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      RD_USER,
      RD_STREAM,
      RD_CLOCK,
      RD_SUM_HI,
      RD_SUM_LO
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_INIT,
      WR_RANGE,
      WR_CLOCK,
      WR_SUM_HI,
      WR_SUM_LO
   } wr_sel_type;

   typedef struct packed {
      logic             load_req;
      logic             ptr_clr;
      logic             ptr_inc;
      logic             sum_clr;
      logic             rd_en;
      logic             rd_acc;
      rd_sel_type       rd_sel;
      logic             wr_en;
      wr_sel_type       wr_sel;
      logic             cap_hi;
      logic             wo_clr;
      logic             wo_adv;
      logic             rsp_load;
      logic [ST_W-1:0]  rsp_status;
      logic             rsp_use_rd;
      logic             rsp_last;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            dev_present;
      logic            tt_mode;
      logic            range_ok;
      logic            clock_ok;
      logic            ptr_last;
      logic            stream_last;
      logic            sum_match;
      logic            wr_done;
      logic            rsp_free;
   } sts_type;

   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         3'd0:    val = 8'h00;
         3'd1:    val = 8'h2f;
         3'd2:    val = 8'h20;
         3'd3:    val = 8'hff;
         3'd4:    val = 8'hff;
         3'd5:    val = 8'hff;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/nvcs_dp.sv
// Datapath: request registers, byte store with valid bits, checksum accumulator, result register.
module nvcs_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  nvcs_pkg::cmd_type               cmd,
   output nvcs_pkg::sts_type               sts,
   input  logic [nvcs_pkg::OP_W-1:0]       req_operation,
   input  logic [nvcs_pkg::IDX_W-1:0]      req_start_req,
   input  logic [nvcs_pkg::IDX_W-1:0]      req_count,
   input  logic [nvcs_pkg::BYTE_W-1:0]     req_data_in,
   input  logic                            csr_write_en,
   input  logic                            csr_index,
   input  logic                            csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [nvcs_pkg::ST_W-1:0]       rsp_status,
   output logic [nvcs_pkg::BYTE_W-1:0]     rsp_data_out,
   output logic                            rsp_last
);

   localparam int AW = nvcs_pkg::ADDR_W;
   localparam int UW = nvcs_pkg::UIDX_W;
   localparam int IW = nvcs_pkg::IDX_W;
   localparam int BW = nvcs_pkg::BYTE_W;

   logic [nvcs_pkg::OP_W-1:0] op_ff;
   logic [IW-1:0]             start_ff;
   logic [IW-1:0]             count_ff;
   logic [BW-1:0]             data_ff;
   logic                      dev_present_ff;
   logic                      tt_mode_ff;
   logic [IW-1:0]             wo_ff;
   logic [IW-1:0]             wo_in;
   logic [UW-1:0]             ptr_ff;
   logic [BW-1:0]             sum_ff;
   logic [BW-1:0]             hi_ff;
   logic                      acc_pend_ff;

   logic [BW-1:0]             mem [nvcs_pkg::STORE_BYTES];
   logic [nvcs_pkg::STORE_BYTES-1:0] valid_ff;
   logic [BW-1:0]             rd_data_ff;
   logic                      rd_valid_ff;
   logic [BW-1:0]             rd_word;

   logic                      rsp_valid_ff;
   logic [nvcs_pkg::ST_W-1:0] rsp_status_ff;
   logic [BW-1:0]             rsp_data_ff;
   logic                      rsp_last_ff;

   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;
   logic [BW-1:0]             wr_byte;
   logic [BW-1:0]             init_byte;
   logic                      in_pattern;
   logic [IW-1:0]             wo_eff;
   logic [IW-1:0]             wo_nxt;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_operation;
         start_ff <= req_start_req;
         count_ff <= req_count;
         data_ff  <= req_data_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_present_ff <= 1'b1;
         tt_mode_ff     <= 1'b0;
      end else if (csr_write_en) begin
         if (csr_index == nvcs_pkg::CSR_DEVICE_PRESENT) dev_present_ff <= csr_write_data;
         if (csr_index == nvcs_pkg::CSR_TT_MODE)        tt_mode_ff     <= csr_write_data;
      end
   end

   // Range write progress. A progress value at or beyond the count restarts the range.
   assign wo_eff = (wo_ff >= count_ff) ? '0 : wo_ff;
   assign wo_nxt = wo_eff + IW'(1);

   always_comb begin
      wo_in = wo_ff;
      if (cmd.wo_clr) begin
         wo_in = '0;
      end else if (cmd.wo_adv) begin
         wo_in = (wo_nxt >= count_ff) ? '0 : wo_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wo_ff <= '0;
      end else begin
         wo_ff <= wo_in;
      end
   end

   // Walk pointer over the user area or over the streamed range.
   always_ff @(posedge clock) begin
      if (cmd.ptr_clr) begin
         ptr_ff <= '0;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + UW'(1);
      end
   end

   // Initialization byte for the current user offset.
   assign in_pattern = !tt_mode_ff && nvcs_pkg::PATTERN_FITS
                       && (ptr_ff >= UW'(nvcs_pkg::PATTERN_AT))
                       && (ptr_ff < UW'(nvcs_pkg::PATTERN_AT + nvcs_pkg::PATTERN_LEN));
   assign init_byte  = in_pattern
                       ? nvcs_pkg::pattern_byte(nvcs_pkg::PAT_W'(ptr_ff - UW'(nvcs_pkg::PATTERN_AT)))
                       : '0;

   // Address and data selection for the single read and single write port.
   always_comb begin
      unique case (cmd.rd_sel)
         nvcs_pkg::RD_USER:   rd_addr = AW'(nvcs_pkg::CLOCK_BYTES) + AW'(ptr_ff);
         nvcs_pkg::RD_STREAM: rd_addr = AW'(nvcs_pkg::CLOCK_BYTES) + AW'(start_ff) + AW'(ptr_ff);
         nvcs_pkg::RD_CLOCK:  rd_addr = AW'(start_ff);
         nvcs_pkg::RD_SUM_HI: rd_addr = AW'(nvcs_pkg::SUM_ADDR);
         nvcs_pkg::RD_SUM_LO: rd_addr = AW'(nvcs_pkg::SUM_ADDR + 1);
         default:             rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         nvcs_pkg::WR_INIT: begin
            wr_addr = AW'(nvcs_pkg::CLOCK_BYTES) + AW'(ptr_ff);
            wr_byte = init_byte;
         end
         nvcs_pkg::WR_RANGE: begin
            wr_addr = AW'(nvcs_pkg::CLOCK_BYTES) + AW'(start_ff) + AW'(wo_eff);
            wr_byte = data_ff;
         end
         nvcs_pkg::WR_CLOCK: begin
            wr_addr = AW'(start_ff);
            wr_byte = data_ff;
         end
         nvcs_pkg::WR_SUM_HI: begin
            wr_addr = AW'(nvcs_pkg::SUM_ADDR);
            wr_byte = ~sum_ff;
         end
         nvcs_pkg::WR_SUM_LO: begin
            wr_addr = AW'(nvcs_pkg::SUM_ADDR + 1);
            wr_byte = sum_ff;
         end
         default: begin
            wr_addr = '0;
            wr_byte = '0;
         end
      endcase
   end

   // Byte store. An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

   // Checksum accumulation, one byte a cycle: init bytes on write, read bytes in the cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_pend_ff <= 1'b0;
      end else begin
         acc_pend_ff <= cmd.rd_en && cmd.rd_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_clr) begin
         sum_ff <= '0;
      end else if (cmd.wr_en && cmd.wr_sel == nvcs_pkg::WR_INIT) begin
         sum_ff <= sum_ff + init_byte;
      end else if (acc_pend_ff) begin
         sum_ff <= sum_ff + rd_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_hi) begin
         hi_ff <= rd_word;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_data_ff   <= cmd.rsp_use_rd ? rd_word : '0;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_last     = rsp_last_ff;

   // Status toward the controller.
   always_comb begin
      sts.op          = op_ff;
      sts.dev_present = dev_present_ff;
      sts.tt_mode     = tt_mode_ff;
      sts.range_ok    = (count_ff != '0)
                        && (({1'b0, start_ff} + {1'b0, count_ff})
                            <= (IW+1)'(nvcs_pkg::USER_BYTES));
      sts.clock_ok    = ({1'b0, start_ff} < (IW+1)'(nvcs_pkg::CLOCK_BYTES));
      sts.ptr_last    = (ptr_ff == UW'(nvcs_pkg::USER_BYTES - 1));
      sts.stream_last = (IW'(ptr_ff) == count_ff - IW'(1));
      sts.sum_match   = (hi_ff == ~sum_ff) && (rd_word == sum_ff);
      sts.wr_done     = (wo_nxt >= count_ff);
      sts.rsp_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

### rtl/core/nvcs_ctrl.sv
// Controller: sequences each request through decode, store walks and result delivery.
module nvcs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nvcs_pkg::sts_type sts,
   output nvcs_pkg::cmd_type cmd
);

   nvcs_pkg::state_type state_ff;
   nvcs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nvcs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nvcs_pkg::S_IDLE: begin
            if (req_valid) state_in = nvcs_pkg::S_DECODE;
         end
         nvcs_pkg::S_DECODE: begin
            if (!sts.dev_present) begin
               if (sts.rsp_free) state_in = nvcs_pkg::S_IDLE;
            end else begin
               unique case (sts.op)
                  nvcs_pkg::OP_RESET:  state_in = nvcs_pkg::S_INIT_WALK;
                  nvcs_pkg::OP_CLK_RD: state_in = nvcs_pkg::S_CLK_OUT;
                  nvcs_pkg::OP_CLK_WR: state_in = nvcs_pkg::S_RESPOND;
                  nvcs_pkg::OP_RANGE_RD: begin
                     if (sts.range_ok) state_in = nvcs_pkg::S_SUM_WALK;
                     else if (sts.rsp_free) state_in = nvcs_pkg::S_IDLE;
                  end
                  nvcs_pkg::OP_RANGE_WR: begin
                     if (!sts.range_ok) begin
                        if (sts.rsp_free) state_in = nvcs_pkg::S_IDLE;
                     end else if (sts.wr_done) begin
                        state_in = nvcs_pkg::S_SUM_WALK;
                     end else begin
                        state_in = nvcs_pkg::S_RESPOND;
                     end
                  end
                  default: begin
                     if (sts.rsp_free) state_in = nvcs_pkg::S_IDLE;
                  end
               endcase
            end
         end
         nvcs_pkg::S_INIT_WALK: begin
            if (sts.ptr_last) begin
               state_in = (sts.tt_mode || nvcs_pkg::PATTERN_FITS)
                          ? nvcs_pkg::S_WR_HI : nvcs_pkg::S_RESPOND;
            end
         end
         nvcs_pkg::S_SUM_WALK: begin
            if (sts.ptr_last) state_in = nvcs_pkg::S_SUM_HI;
         end
         nvcs_pkg::S_SUM_HI: begin
            state_in = (sts.op == nvcs_pkg::OP_RANGE_RD)
                       ? nvcs_pkg::S_SUM_LO : nvcs_pkg::S_WR_HI;
         end
         nvcs_pkg::S_SUM_LO:    state_in = nvcs_pkg::S_SUM_CHECK;
         nvcs_pkg::S_SUM_CHECK: begin
            if (sts.sum_match) state_in = nvcs_pkg::S_STREAM_RD;
            else if (sts.rsp_free) state_in = nvcs_pkg::S_IDLE;
         end
         nvcs_pkg::S_WR_HI:     state_in = nvcs_pkg::S_WR_LO;
         nvcs_pkg::S_WR_LO:     state_in = nvcs_pkg::S_RESPOND;
         nvcs_pkg::S_STREAM_RD: state_in = nvcs_pkg::S_STREAM_OUT;
         nvcs_pkg::S_STREAM_OUT: begin
            if (sts.rsp_free) begin
               state_in = sts.stream_last ? nvcs_pkg::S_IDLE : nvcs_pkg::S_STREAM_RD;
            end
         end
         nvcs_pkg::S_CLK_OUT, nvcs_pkg::S_RESPOND: begin
            if (sts.rsp_free) state_in = nvcs_pkg::S_IDLE;
         end
         default: state_in = nvcs_pkg::S_IDLE;
      endcase
   end

   // Commands.
   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = nvcs_pkg::RD_USER;
      cmd.wr_sel     = nvcs_pkg::WR_INIT;
      cmd.rsp_status = nvcs_pkg::ST_OK;
      cmd.rsp_last   = 1'b1;
      req_stall      = 1'b1;
      unique case (state_ff)
         nvcs_pkg::S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         nvcs_pkg::S_DECODE: begin
            cmd.ptr_clr = 1'b1;
            cmd.sum_clr = 1'b1;
            cmd.wo_clr  = (sts.op != nvcs_pkg::OP_RANGE_WR) || !sts.dev_present
                          || !sts.range_ok;
            if (!sts.dev_present) begin
               cmd.rsp_load   = sts.rsp_free;
               cmd.rsp_status = (sts.op == nvcs_pkg::OP_CLK_RD)
                                ? nvcs_pkg::ST_OK : nvcs_pkg::ST_NODEV;
            end else begin
               unique case (sts.op)
                  nvcs_pkg::OP_RESET: ;
                  nvcs_pkg::OP_CLK_RD: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = nvcs_pkg::RD_CLOCK;
                  end
                  nvcs_pkg::OP_CLK_WR: begin
                     cmd.wr_en  = sts.clock_ok;
                     cmd.wr_sel = nvcs_pkg::WR_CLOCK;
                  end
                  nvcs_pkg::OP_RANGE_RD: begin
                     if (!sts.range_ok) begin
                        cmd.rsp_load   = sts.rsp_free;
                        cmd.rsp_status = nvcs_pkg::ST_BAD;
                     end
                  end
                  nvcs_pkg::OP_RANGE_WR: begin
                     if (!sts.range_ok) begin
                        cmd.rsp_load   = sts.rsp_free;
                        cmd.rsp_status = nvcs_pkg::ST_BAD;
                     end else begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_sel = nvcs_pkg::WR_RANGE;
                        cmd.wo_adv = 1'b1;
                     end
                  end
                  default: begin
                     cmd.rsp_load   = sts.rsp_free;
                     cmd.rsp_status = nvcs_pkg::ST_BAD;
                  end
               endcase
            end
         end
         nvcs_pkg::S_INIT_WALK: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = nvcs_pkg::WR_INIT;
            cmd.ptr_inc = !sts.ptr_last;
         end
         nvcs_pkg::S_SUM_WALK: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_acc  = 1'b1;
            cmd.rd_sel  = nvcs_pkg::RD_USER;
            cmd.ptr_inc = !sts.ptr_last;
         end
         nvcs_pkg::S_SUM_HI: begin
            cmd.rd_en  = (sts.op == nvcs_pkg::OP_RANGE_RD);
            cmd.rd_sel = nvcs_pkg::RD_SUM_HI;
         end
         nvcs_pkg::S_SUM_LO: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = nvcs_pkg::RD_SUM_LO;
            cmd.cap_hi = 1'b1;
         end
         nvcs_pkg::S_SUM_CHECK: begin
            if (sts.sum_match) begin
               cmd.ptr_clr = 1'b1;
            end else begin
               cmd.rsp_load   = sts.rsp_free;
               cmd.rsp_status = nvcs_pkg::ST_SUM;
            end
         end
         nvcs_pkg::S_WR_HI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = nvcs_pkg::WR_SUM_HI;
         end
         nvcs_pkg::S_WR_LO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = nvcs_pkg::WR_SUM_LO;
         end
         nvcs_pkg::S_STREAM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = nvcs_pkg::RD_STREAM;
         end
         nvcs_pkg::S_STREAM_OUT: begin
            cmd.rsp_load   = sts.rsp_free;
            cmd.rsp_use_rd = 1'b1;
            cmd.rsp_last   = sts.stream_last;
            cmd.ptr_inc    = sts.rsp_free && !sts.stream_last;
         end
         nvcs_pkg::S_CLK_OUT: begin
            cmd.rsp_load   = sts.rsp_free;
            cmd.rsp_use_rd = sts.clock_ok;
         end
         nvcs_pkg::S_RESPOND: begin
            cmd.rsp_load = sts.rsp_free;
         end
         default: ;
      endcase
   end

endmodule

### rtl/core/nvram_with_checksum_guard_core.sv
// Top level of the checksum-guarded non-volatile byte store: controller plus datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  operation, start_req, count, data_in
//   rsp      out        rsp_valid / rsp_stall  status, data_out, last
//   csr      in         csr_write_en           csr_index, csr_write_data
//
// One request at a time. Checksum work walks the user bytes one a cycle; a reset, a
// range-finishing write byte and a range read each make that walk, and a range read whose
// checksum matches then streams its count of bytes. A bad request, a missing device,
// a clock access and a range write byte that leaves the range open skip the walk.
// Reset is synchronous; store entries carry valid bits that reset clears, so no clearing pass.
// A held result stalls the controller; a new request is taken as soon as it is idle again.
module nvram_with_checksum_guard_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [nvcs_pkg::OP_W-1:0]    req_operation,
   input  logic [nvcs_pkg::IDX_W-1:0]   req_start_req,
   input  logic [nvcs_pkg::IDX_W-1:0]   req_count,
   input  logic [nvcs_pkg::BYTE_W-1:0]  req_data_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [nvcs_pkg::ST_W-1:0]    rsp_status,
   output logic [nvcs_pkg::BYTE_W-1:0]  rsp_data_out,
   output logic                         rsp_last,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic                         csr_write_data
);

   nvcs_pkg::cmd_type cmd;
   nvcs_pkg::sts_type sts;

   // The controller owns sequencing and the input handshake; every store access,
   // counter and result register lives in the datapath.
   nvcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   nvcs_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_operation  (req_operation),
      .req_start_req  (req_start_req),
      .req_count      (req_count),
      .req_data_in    (req_data_in),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_last       (rsp_last)
   );

   // A transfer on the request side is always followed by a stall of the input.
   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while the previous one was still being decoded");

   // Only a successful range read or clock read carries data, and errors end the item.
   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != nvcs_pkg::ST_OK) |-> (rsp_last && rsp_data_out == '0))
      else $error("error result with data or without the last flag");

   // While a streamed range is still incomplete no new request may be taken.
   a_stream_holds_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request taken in the middle of a range read stream");

endmodule

### sim/tb_nvram_with_checksum_guard_core.sv
// Self-checking testbench for the checksum-guarded byte store: directed and random requests.

// One result as the block should deliver it.
typedef struct packed {
   logic [nvcs_pkg::ST_W-1:0]   status;
   logic [nvcs_pkg::BYTE_W-1:0] data;
   logic                        last;
} store_rsp_type;

// Mirror of the byte store. It applies every accepted request to its own copy of the store
// and queues the results that request must produce, then matches delivered results in order.
class byte_store_mirror;
   localparam logic [8*nvcs_pkg::PATTERN_LEN-1:0] INIT_BYTES = 48'h00_2f_20_ff_ff_ff;

   logic [nvcs_pkg::BYTE_W-1:0] image [nvcs_pkg::STORE_BYTES];
   logic [nvcs_pkg::IDX_W-1:0]  wr_pos;
   bit                          present;
   bit                          tt;
   store_rsp_type               due_responses [$];
   int                          mismatches;

   function new();
      foreach (image[i]) image[i] = '0;
      wr_pos = '0;
      present = 1'b1;
      tt = 1'b0;
      mismatches = 0;
   endfunction

   function void set_register(logic idx, logic val);
      if (idx == nvcs_pkg::CSR_DEVICE_PRESENT) present = val;
      else tt = val;
   endfunction

   function int pending();
      return due_responses.size();
   endfunction

   function logic [nvcs_pkg::BYTE_W-1:0] user_total();
      logic [nvcs_pkg::BYTE_W-1:0] s;
      s = '0;
      for (int i = 0; i < nvcs_pkg::USER_BYTES; i++) s += image[nvcs_pkg::CLOCK_BYTES + i];
      return s;
   endfunction

   // Checksum word: high byte (first address) is the inverted sum, low byte the sum.
   function void seal_checksum();
      logic [nvcs_pkg::BYTE_W-1:0] s;
      s = user_total();
      image[nvcs_pkg::SUM_ADDR]     = ~s;
      image[nvcs_pkg::SUM_ADDR + 1] = s;
   endfunction

   function void queue_response(logic [nvcs_pkg::ST_W-1:0] st,
                                logic [nvcs_pkg::BYTE_W-1:0] d, logic l);
      store_rsp_type r;
      r.status = st;
      r.data   = d;
      r.last   = l;
      due_responses.push_back(r);
   endfunction

   function void take_request(logic [nvcs_pkg::OP_W-1:0] op,
                              logic [nvcs_pkg::IDX_W-1:0] first,
                              logic [nvcs_pkg::IDX_W-1:0] cnt,
                              logic [nvcs_pkg::BYTE_W-1:0] value);
      logic [nvcs_pkg::BYTE_W-1:0] s;
      bit                          fits;
      fits = (cnt != 0) && (int'(first) + int'(cnt) <= nvcs_pkg::USER_BYTES);
      if (op != nvcs_pkg::OP_RANGE_WR) wr_pos = '0;
      if (!present) begin
         wr_pos = '0;
         queue_response((op == nvcs_pkg::OP_CLK_RD) ? nvcs_pkg::ST_OK : nvcs_pkg::ST_NODEV,
                        '0, 1'b1);
         return;
      end
      case (op)
         nvcs_pkg::OP_RESET: begin
            for (int i = 0; i < nvcs_pkg::USER_BYTES; i++)
               image[nvcs_pkg::CLOCK_BYTES + i] = '0;
            if (tt) begin
               seal_checksum();
            end else if (nvcs_pkg::PATTERN_FITS) begin
               for (int i = 0; i < nvcs_pkg::PATTERN_LEN; i++)
                  image[nvcs_pkg::CLOCK_BYTES + nvcs_pkg::PATTERN_AT + i] =
                     INIT_BYTES[8*(nvcs_pkg::PATTERN_LEN-1-i) +: 8];
               seal_checksum();
            end
            queue_response(nvcs_pkg::ST_OK, '0, 1'b1);
         end
         nvcs_pkg::OP_CLK_RD: begin
            queue_response(nvcs_pkg::ST_OK,
                           (first < nvcs_pkg::CLOCK_BYTES) ? image[first] : '0, 1'b1);
         end
         nvcs_pkg::OP_CLK_WR: begin
            if (first < nvcs_pkg::CLOCK_BYTES) image[first] = value;
            queue_response(nvcs_pkg::ST_OK, '0, 1'b1);
         end
         nvcs_pkg::OP_RANGE_RD: begin
            s = user_total();
            if (!fits) begin
               queue_response(nvcs_pkg::ST_BAD, '0, 1'b1);
            end else if (image[nvcs_pkg::SUM_ADDR] != ~s
                         || image[nvcs_pkg::SUM_ADDR + 1] != s) begin
               queue_response(nvcs_pkg::ST_SUM, '0, 1'b1);
            end else begin
               for (int i = 0; i < int'(cnt); i++)
                  queue_response(nvcs_pkg::ST_OK,
                                 image[nvcs_pkg::CLOCK_BYTES + int'(first) + i],
                                 i + 1 == int'(cnt));
            end
         end
         nvcs_pkg::OP_RANGE_WR: begin
            if (!fits) begin
               wr_pos = '0;
               queue_response(nvcs_pkg::ST_BAD, '0, 1'b1);
            end else begin
               if (wr_pos >= cnt) wr_pos = '0;
               image[nvcs_pkg::CLOCK_BYTES + int'(first) + int'(wr_pos)] = value;
               wr_pos = wr_pos + 1'b1;
               if (wr_pos >= cnt) begin
                  seal_checksum();
                  wr_pos = '0;
               end
               queue_response(nvcs_pkg::ST_OK, '0, 1'b1);
            end
         end
         default: queue_response(nvcs_pkg::ST_BAD, '0, 1'b1);
      endcase
   endfunction

   function void match_response(logic [nvcs_pkg::ST_W-1:0] st,
                                logic [nvcs_pkg::BYTE_W-1:0] d, logic l);
      store_rsp_type want;
      if (due_responses.size() == 0) begin
         $error("result with nothing due: status %0d data %02h last %0d", st, d, l);
         mismatches++;
         return;
      end
      want = due_responses.pop_front();
      if (st !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, st);
         mismatches++;
      end
      if (d !== want.data) begin
         $error("data_out: expected %02h, actual %02h", want.data, d);
         mismatches++;
      end
      if (l !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, l);
         mismatches++;
      end
   endfunction
endclass

module tb_nvram_with_checksum_guard_core;

   // Field widths of the request channel.
   localparam int OW = nvcs_pkg::OP_W;
   localparam int IW = nvcs_pkg::IDX_W;
   localparam int BW = nvcs_pkg::BYTE_W;

   // Operation codes outside the defined set; the block must reject them.
   localparam logic [OW-1:0] OP_BAD_LO = 3'd5;
   localparam logic [OW-1:0] OP_BAD_HI = 3'd7;

   // Length of the long output hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES = 400;
   // Margin after the last result before a register write or the verdict.
   localparam int SETTLE_CYCLES = 8;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [OW-1:0]                 req_operation;
   logic [IW-1:0]                 req_start_req;
   logic [IW-1:0]                 req_count;
   logic [BW-1:0]                 req_data_in;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [nvcs_pkg::ST_W-1:0]     rsp_status;
   logic [BW-1:0]                 rsp_data_out;
   logic                          rsp_last;
   logic                          csr_write_en;
   logic                          csr_index;
   logic                          csr_write_data;

   byte_store_mirror     board = new();

   // Idle rates in percent for the sender and the receiver; changed between phases.
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   items_sent = 0;

   // The stimulus asks for a hold-off by bumping hold_asked; the receiver counts it out.
   int                   hold_asked = 0;
   int                   hold_given = 0;
   int                   hold_left = 0;

   nvram_with_checksum_guard_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_start_req  (req_start_req),
      .req_count      (req_count),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // Receiver. The check uses the stall value that the block saw at this edge, and only then
   // is the stall for the next cycle chosen: a pending hold-off wins over random idling.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         board.match_response(rsp_status, rsp_data_out, rsp_last);
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_given) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         hold_given <= hold_asked;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one request and return at the edge where the transfer happens. Valid is lowered
   // only while idling, so back-to-back requests keep it high with no glitch in between.
   task automatic send_item(input int op, input int first, input int cnt, input int value);
      logic [OW-1:0] op_b;
      logic [IW-1:0] first_b;
      logic [IW-1:0] cnt_b;
      logic [BW-1:0] value_b;
      op_b    = OW'(op);
      first_b = IW'(first);
      cnt_b   = IW'(cnt);
      value_b = BW'(value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op_b;
      req_start_req <= first_b;
      req_count     <= cnt_b;
      req_data_in   <= value_b;
      do @(posedge clock); while (req_stall);
      board.take_request(op_b, first_b, cnt_b, value_b);
      items_sent++;
   endtask

   // Drop valid and wait until every due result has come back, plus a short margin.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers are written on every call, one per edge; the block must be idle.
   task automatic configure(input logic present, input logic tt);
      csr_write_en   <= 1'b1;
      csr_index      <= nvcs_pkg::CSR_DEVICE_PRESENT;
      csr_write_data <= present;
      @(posedge clock);
      board.set_register(nvcs_pkg::CSR_DEVICE_PRESENT, present);
      csr_index      <= nvcs_pkg::CSR_TT_MODE;
      csr_write_data <= tt;
      @(posedge clock);
      board.set_register(nvcs_pkg::CSR_TT_MODE, tt);
      csr_write_en   <= 1'b0;
   endtask

   // Range length for a well-formed request: mostly short, now and then up to the room left.
   function automatic int span_for(int room);
      if (room > 8 && $urandom_range(9) == 0) return $urandom_range(room, 1);
      return $urandom_range((room < 8) ? room : 8, 1);
   endfunction

   task automatic run_directed();
      // A fresh store has a zero checksum word, which can never match a zero sum.
      send_item(nvcs_pkg::OP_RANGE_RD, 0, nvcs_pkg::USER_BYTES, $urandom);
      // Reset writes the init pattern and seals; a full-width read then streams it all.
      send_item(nvcs_pkg::OP_RESET, $urandom, $urandom, $urandom);
      send_item(nvcs_pkg::OP_RANGE_RD, 0, nvcs_pkg::USER_BYTES, 8'h00);
      // One-byte range at the top of the user area finishes at once and reseals.
      send_item(nvcs_pkg::OP_RANGE_WR, nvcs_pkg::USER_BYTES - 1, 1, 8'hff);
      // A range write cut short by another operation starts over at its first byte.
      send_item(nvcs_pkg::OP_RANGE_WR, 0, 4, 8'ha5);
      send_item(nvcs_pkg::OP_RANGE_WR, 0, 4, 8'h5a);
      send_item(nvcs_pkg::OP_CLK_RD, nvcs_pkg::CLOCK_BYTES - 1, 0, 8'h00);
      send_item(nvcs_pkg::OP_RANGE_WR, 0, 4, 8'h01);
      // The count drops to the progress made, so the range restarts and completes.
      send_item(nvcs_pkg::OP_RANGE_WR, 0, 1, 8'h02);
      // Clock area: first index, the first index past the end, and the largest index.
      send_item(nvcs_pkg::OP_CLK_WR, 0, 0, 8'hff);
      send_item(nvcs_pkg::OP_CLK_WR, nvcs_pkg::CLOCK_BYTES, 0, 8'h55);
      send_item(nvcs_pkg::OP_CLK_RD, 0, 6'h3f, 8'h00);
      send_item(nvcs_pkg::OP_CLK_RD, 6'h3f, 6'h3f, 8'hff);
      // Bad ranges: an empty one and one that runs past the user area.
      send_item(nvcs_pkg::OP_RANGE_RD, 0, 0, 8'h00);
      send_item(nvcs_pkg::OP_RANGE_WR, 1, nvcs_pkg::USER_BYTES, 8'h3c);
      send_item(OP_BAD_LO, 0, 1, 8'h00);
      send_item(OP_BAD_HI, 6'h3f, 6'h3f, 8'hff);
      // An unfinished range write leaves the checksum stale, so the next read must fail it.
      send_item(nvcs_pkg::OP_RANGE_WR, 5, 3, 8'h77);
      send_item(nvcs_pkg::OP_RANGE_RD, 0, 2, 8'h00);
      wait_drained();

      // In tt mode reset only zeroes the user area and reseals.
      configure(1'b1, 1'b1);
      send_item(nvcs_pkg::OP_RESET, 0, 0, 8'h00);
      send_item(nvcs_pkg::OP_RANGE_RD, nvcs_pkg::PATTERN_AT, nvcs_pkg::PATTERN_LEN, 8'h00);
      wait_drained();

      // Without a device everything fails except a clock read, which answers zero.
      configure(1'b0, 1'b1);
      send_item(nvcs_pkg::OP_RANGE_RD, 0, 1, 8'h00);
      send_item(nvcs_pkg::OP_RANGE_WR, 0, 1, 8'hc3);
      send_item(nvcs_pkg::OP_RESET, 0, 0, 8'h00);
      send_item(nvcs_pkg::OP_CLK_RD, 0, 0, 8'h00);
      wait_drained();
   endtask

   // Random traffic until the running item total reaches goal. Most of it is well-formed:
   // whole range writes with random bytes and reads of valid ranges, so that reads mostly
   // pass the checksum test and stream data. The rest is clock access, resets, broken
   // writes, bad ranges and raw random requests.
   task automatic random_burst(input int goal);
      int pick;
      int first;
      int cnt;
      int stop_at;
      while (items_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            first = $urandom_range(nvcs_pkg::USER_BYTES - 1, 0);
            cnt = span_for(nvcs_pkg::USER_BYTES - first);
            stop_at = ($urandom_range(9) == 0) ? $urandom_range(cnt, 1) : cnt;
            for (int k = 0; k < stop_at; k++)
               send_item(nvcs_pkg::OP_RANGE_WR, first, cnt, $urandom);
         end else if (pick < 55) begin
            first = $urandom_range(nvcs_pkg::USER_BYTES - 1, 0);
            send_item(nvcs_pkg::OP_RANGE_RD, first, span_for(nvcs_pkg::USER_BYTES - first),
                      $urandom);
         end else if (pick < 63) begin
            send_item(nvcs_pkg::OP_RESET, $urandom, $urandom, $urandom);
         end else if (pick < 78) begin
            send_item($urandom_range(1) ? nvcs_pkg::OP_CLK_RD : nvcs_pkg::OP_CLK_WR,
                      $urandom_range(nvcs_pkg::CLOCK_BYTES + 1, 0), $urandom, $urandom);
         end else if (pick < 88) begin
            if ($urandom_range(1)) begin
               first = $urandom_range(63, 0);
               cnt = 0;
            end else begin
               first = $urandom_range(63, 1);
               cnt = $urandom_range(63, (first > nvcs_pkg::USER_BYTES)
                                        ? 1 : nvcs_pkg::USER_BYTES + 1 - first);
            end
            send_item($urandom_range(1) ? nvcs_pkg::OP_RANGE_RD : nvcs_pkg::OP_RANGE_WR,
                      first, cnt, $urandom);
         end else begin
            send_item($urandom_range(7, 0), $urandom, $urandom, $urandom);
         end
      end
   endtask

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("[nvram_with_checksum_guard_core] ERROR");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_operation  <= nvcs_pkg::OP_RANGE_RD;
      req_start_req  <= '0;
      req_count      <= '0;
      req_data_in    <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= nvcs_pkg::CSR_DEVICE_PRESENT;
      csr_write_data <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // First phase: the sender rarely idles, the receiver mostly stalls.
      send_idle_pct = 17;
      recv_idle_pct = 85;
      configure(1'b1, 1'b0);
      run_directed();
      configure(1'b1, 1'b0);
      random_burst(items_sent + 128);
      wait_drained();

      // Second phase: the sender mostly idles, the receiver rarely stalls. A stretch with
      // no device sits in the middle, with tt mode on around it.
      send_idle_pct = 85;
      recv_idle_pct = 17;
      configure(1'b1, 1'b1);
      random_burst(items_sent + 54);
      wait_drained();
      configure(1'b0, 1'b1);
      random_burst(items_sent + 20);
      wait_drained();
      configure(1'b1, 1'b1);
      random_burst(items_sent + 54);
      wait_drained();

      // Third phase: no idling at all. First the receiver holds off for a long stretch while
      // the sender keeps offering short requests, so the block backs up and stalls its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(1'b1, 1'b0);
      hold_asked <= hold_asked + 1;
      repeat (12)
         send_item($urandom_range(1) ? nvcs_pkg::OP_CLK_RD : nvcs_pkg::OP_CLK_WR,
                   $urandom_range(nvcs_pkg::CLOCK_BYTES - 1, 0), $urandom, $urandom);
      random_burst(items_sent + 50);
      // The sender pauses here until every due result has been delivered.
      wait_drained();
      random_burst(items_sent + 60);
      wait_drained();
      repeat (2 * nvcs_pkg::USER_BYTES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[nvram_with_checksum_guard_core] OK");
      end else begin
         $display("[nvram_with_checksum_guard_core] ERROR");
      end
      $finish;
   end

endmodule
